// ===== src/lbd_pkg.sv =====
// Shared types, constants and register codes of the letterbox border detector.
`default_nettype none
package lbd_pkg;

  localparam int CNT_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_NUM_W  = 24;
  localparam int DIV_DEN_W  = 14;
  localparam int DIV_CNT_W  = 5;
  localparam int DIV_STEPS  = DIV_NUM_W;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int DEFAULT_PCT = 16;
  localparam int PCT_SCALE   = 100;

  localparam logic [11:0] FW_RESET   = 12'd720;
  localparam logic [11:0] FH_RESET   = 12'd480;
  localparam logic [7:0]  OV_RESET   = 8'd0;
  localparam logic [6:0]  SKIP_RESET = 7'd1;
  localparam logic [6:0]  THR_RESET  = 7'd40;
  localparam logic [7:0]  PCT_RESET  = 8'hff;
  localparam logic [11:0] FAM_RESET  = 12'd1333;
  localparam logic [11:0] IGNORE_RESET = 12'(720 * DEFAULT_PCT / PCT_SCALE);

  localparam logic [15:0] ASPECT_MAX = 16'hffff;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_OVERSCAN     = 3'd2,
    REG_SKIP_STEP    = 3'd3,
    REG_LUMA_THRESH  = 3'd4,
    REG_IGNORE_PCT   = 3'd5,
    REG_FRAME_ASPECT = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    IG_IDLE,
    IG_START,
    IG_WAIT
  } ign_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [7:0]  overscan;
    logic [6:0]  skip_eff;
    logic [6:0]  luma_threshold;
    logic [11:0] aspect_milli;
    logic [11:0] ignore_limit;
  } cfg_t;

  typedef struct packed {
    logic [10:0] top;
    logic [11:0] bottom;
    logic [10:0] border;
    logic        div_ok;
    logic [11:0] h2;
    logic [11:0] d;
    logic [11:0] fam;
  } frame_sum_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/letterbox_border_detector.sv =====
// Letterbox border detector top level.
//
// Luma samples enter on the s_ stream in raster order, one per transaction, with
// the line end flag in s_tuser and the frame end mark in s_tlast. Rows are
// classified as the samples arrive, so a frame is taken at one sample per cycle,
// stalling only after frame end until the summary is queued and during cfg writes.
// One result per frame leaves on the m_ stream, once the 24-step serial divider
// has formed the aspect ratio, or saturated when no division is possible. Up to
// two frame summaries queue ahead of the divider, so the input keeps flowing while
// a result waits for the receiver; when both slots are full the input stalls at
// the next frame end.
// Registers are written through the cfg_ channel while the block is idle. Each
// write holds s_tready low while the row ignore limit is recomputed, using the
// divider if percent > 0. Reset restores the register defaults and the default
// ignore limit at once and clears all counters; no result is pending after reset.
`default_nettype none
module letterbox_border_detector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // luma[7:0]
  input  wire logic                            s_tuser,   // line_end
  input  wire logic                            s_tlast,   // frame_end
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // top_border[10:0], bottom_border[22:11], min_border[33:23], aspect_milli[49:34]
  output logic [55:0]                          m_tdata,
  output logic                                 m_tuser,   // ratio_saturated
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lbd_pkg::cfg_t       cfg;
  lbd_pkg::div_req_t   cfg_div_req;
  lbd_pkg::div_req_t   back_div_req;
  lbd_pkg::div_req_t   div_req;
  lbd_pkg::div_rsp_t   div_rsp;
  lbd_pkg::frame_sum_t q_din;
  lbd_pkg::frame_sum_t q_dout;
  logic                ign_busy;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic                back_idle;
  logic [10:0]         top_border;
  logic [11:0]         bottom_border;
  logic [10:0]         min_border;
  logic [15:0]         aspect_milli;

  lbd_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .block_idle (back_idle && q_empty),
    .div_rsp    (div_rsp),
    .div_req    (cfg_div_req),
    .cfg        (cfg),
    .ign_busy   (ign_busy)
  );

  lbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .luma      (s_tdata),
    .line_end  (s_tuser),
    .frame_end (s_tlast),
    .cfg       (cfg),
    .ign_busy  (ign_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  lbd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign div_req = cfg_div_req.start ? cfg_div_req : back_div_req;

  lbd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lbd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_dout          (q_dout),
    .q_pop           (q_pop),
    .ign_busy        (ign_busy),
    .div_rsp         (div_rsp),
    .div_req         (back_div_req),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .top_border      (top_border),
    .bottom_border   (bottom_border),
    .min_border      (min_border),
    .aspect_milli    (aspect_milli),
    .ratio_saturated (m_tuser),
    .back_idle       (back_idle)
  );

  assign m_tdata = {6'b0, aspect_milli, min_border, bottom_border, top_border};

`ifndef SYNTH
  a_div_single_owner: assert property (@(posedge clk) disable iff (rst)
    !(cfg_div_req.start && back_div_req.start))
    else $error("divider requested by both users");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_no_input_during_limit: assert property (@(posedge clk) disable iff (rst)
    ign_busy |-> !s_tready)
    else $error("input accepted while ignore limit is recomputed");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("summary queue overflow");
`endif

endmodule
`default_nettype wire

// ===== src/lbd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module lbd_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lbd_pkg::div_req_t req,
  output lbd_pkg::div_rsp_t      rsp
);

  logic                          busy;
  logic                          done;
  logic [lbd_pkg::DIV_NUM_W-1:0] q;
  logic [lbd_pkg::DIV_DEN_W-1:0] rem;
  logic [lbd_pkg::DIV_DEN_W-1:0] den;
  logic [lbd_pkg::DIV_CNT_W-1:0] cnt;
  logic [lbd_pkg::DIV_DEN_W:0]   trial;
  logic                          ge;

  assign trial = {rem, q[lbd_pkg::DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lbd_pkg::DIV_CNT_W'(lbd_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      q   <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? lbd_pkg::DIV_DEN_W'(trial - {1'b0, den})
                : trial[lbd_pkg::DIV_DEN_W-1:0];
      q   <= {q[lbd_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = q;

endmodule
`default_nettype wire

// ===== src/lbd_cfg.sv =====
// Configuration registers and the ignore limit derived from them.
`default_nettype none
module lbd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             block_idle,
  input  wire lbd_pkg::div_rsp_t                div_rsp,
  output lbd_pkg::div_req_t                     div_req,
  output lbd_pkg::cfg_t                         cfg,
  output logic                                  ign_busy
);

  lbd_pkg::ign_state_t state;
  lbd_pkg::ign_state_t state_next;

  logic [11:0]       frame_width;
  logic [11:0]       frame_height;
  logic [7:0]        overscan;
  logic [6:0]        skip_step;
  logic [6:0]        luma_threshold;
  logic [7:0]        ignore_percent;
  logic [11:0]       frame_aspect_milli;
  logic [11:0]       ignore_limit;

  logic              wr;
  logic [6:0]        skip_eff;
  logic signed [7:0] pct_eff;
  logic              pct_pos;
  logic [18:0]       prod;
  logic [13:0]       den;
  logic [11:0]       limit_clamped;

  assign cfg_ready = block_idle && !ign_busy && !div_rsp.busy;
  assign wr        = cfg_valid && cfg_ready;
  assign ign_busy  = state != lbd_pkg::IG_IDLE;

  assign skip_eff = (skip_step == '0) ? 7'd1 : skip_step;
  assign pct_eff  = ($signed(ignore_percent) == -8'sd1) ?
                    8'(lbd_pkg::DEFAULT_PCT) : $signed(ignore_percent);
  assign pct_pos  = pct_eff > 8'sd0;
  assign prod     = frame_width * pct_eff[6:0];
  assign den      = skip_eff * 7'(lbd_pkg::PCT_SCALE);

  always_comb begin
    if (div_rsp.quo == '0) begin
      limit_clamped = 12'd1;
    end else if (div_rsp.quo > lbd_pkg::DIV_NUM_W'(lbd_pkg::CNT_MAX)) begin
      limit_clamped = lbd_pkg::CNT_MAX;
    end else begin
      limit_clamped = div_rsp.quo[11:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lbd_pkg::IG_IDLE: begin
        if (wr) state_next = lbd_pkg::IG_START;
      end
      lbd_pkg::IG_START: begin
        if (!div_rsp.busy) state_next = pct_pos ? lbd_pkg::IG_WAIT : lbd_pkg::IG_IDLE;
      end
      lbd_pkg::IG_WAIT: begin
        if (div_rsp.done) state_next = lbd_pkg::IG_IDLE;
      end
      default: state_next = lbd_pkg::IG_IDLE;
    endcase
  end

  always_comb begin
    div_req.start = (state == lbd_pkg::IG_START) && pct_pos && !div_rsp.busy;
    div_req.num   = lbd_pkg::DIV_NUM_W'(prod);
    div_req.den   = den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbd_pkg::IG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width        <= lbd_pkg::FW_RESET;
      frame_height       <= lbd_pkg::FH_RESET;
      overscan           <= lbd_pkg::OV_RESET;
      skip_step          <= lbd_pkg::SKIP_RESET;
      luma_threshold     <= lbd_pkg::THR_RESET;
      ignore_percent     <= lbd_pkg::PCT_RESET;
      frame_aspect_milli <= lbd_pkg::FAM_RESET;
      ignore_limit       <= lbd_pkg::IGNORE_RESET;
    end else begin
      if (wr) begin
        unique case (lbd_pkg::cfg_reg_t'(cfg_index))
          lbd_pkg::REG_FRAME_WIDTH:  frame_width        <= cfg_data;
          lbd_pkg::REG_FRAME_HEIGHT: frame_height       <= cfg_data;
          lbd_pkg::REG_OVERSCAN:     overscan           <= cfg_data[7:0];
          lbd_pkg::REG_SKIP_STEP:    skip_step          <= cfg_data[6:0];
          lbd_pkg::REG_LUMA_THRESH:  luma_threshold     <= cfg_data[6:0];
          lbd_pkg::REG_IGNORE_PCT:   ignore_percent     <= cfg_data[7:0];
          lbd_pkg::REG_FRAME_ASPECT: frame_aspect_milli <= cfg_data;
          default: ;
        endcase
      end
      if (state == lbd_pkg::IG_START && !div_rsp.busy && !pct_pos) begin
        ignore_limit <= '0;
      end else if (state == lbd_pkg::IG_WAIT && div_rsp.done) begin
        ignore_limit <= limit_clamped;
      end
    end
  end

  always_comb begin
    cfg.frame_width    = frame_width;
    cfg.frame_height   = frame_height;
    cfg.overscan       = overscan;
    cfg.skip_eff       = skip_eff;
    cfg.luma_threshold = luma_threshold;
    cfg.aspect_milli   = frame_aspect_milli;
    cfg.ignore_limit   = ignore_limit;
  end

endmodule
`default_nettype wire

// ===== src/lbd_front.sv =====
// Sample intake: column and row counting, row classification and frame summary.
`default_nettype none
module lbd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [7:0]     luma,
  input  wire logic           line_end,
  input  wire logic           frame_end,
  input  wire lbd_pkg::cfg_t  cfg,
  input  wire logic           ign_busy,
  input  wire logic           q_full,
  output logic                q_push,
  output lbd_pkg::frame_sum_t q_din
);

  logic [11:0] column_count;
  logic [11:0] row_count;
  logic [11:0] bright_count;
  logic [6:0]  phase;
  logic        top_found;
  logic [11:0] top_row;
  logic        bottom_found;
  logic [11:0] bottom_row;
  logic        pending;

  logic               accept;
  logic signed [13:0] ov_s;
  logic signed [13:0] ov2_s;
  logic signed [13:0] fw_s;
  logic signed [13:0] fh_s;
  logic signed [13:0] col_lim;
  logic signed [13:0] top_max;
  logic signed [13:0] h2;
  logic signed [13:0] h2_half;
  logic signed [13:0] c_s;
  logic signed [13:0] y_s;
  logic [6:0]         phase_inc;
  logic               examine;
  logic               bright_hit;
  logic [11:0]        bright_inc;
  logic               pic;
  logic               top_hit;
  logic               bot_hit;
  logic signed [13:0] top_s;
  logic signed [13:0] bottom_s;
  logic signed [13:0] border_s;
  logic signed [14:0] d_s;

  assign s_tready = !pending && !ign_busy;
  assign accept   = s_tvalid && s_tready;

  assign ov_s    = $signed({6'b0, cfg.overscan});
  assign ov2_s   = $signed({5'b0, cfg.overscan, 1'b0});
  assign fw_s    = $signed({2'b0, cfg.frame_width});
  assign fh_s    = $signed({2'b0, cfg.frame_height});
  assign col_lim = fw_s - ov2_s;
  assign top_max = $signed({3'b0, cfg.frame_height[11:1]}) - ov_s;
  assign h2      = fh_s - ov2_s;
  assign h2_half = h2 >>> 1;
  assign c_s     = $signed({2'b0, column_count});
  assign y_s     = $signed({2'b0, row_count});

  assign phase_inc  = phase + 7'd1;
  assign examine    = (c_s >= ov_s) && (c_s < col_lim) && (phase == '0);
  assign bright_hit = examine && (luma[6:0] > cfg.luma_threshold) &&
                      (bright_count != lbd_pkg::CNT_MAX);
  assign bright_inc = bright_count + 12'(bright_hit);
  assign pic        = bright_inc > cfg.ignore_limit;
  assign top_hit    = pic && !top_found && (y_s >= ov_s) && (y_s < top_max);
  assign bot_hit    = pic && (y_s >= h2_half) && (y_s < h2);

  always_comb begin
    if (top_found) begin
      top_s = $signed({2'b0, top_row}) - ov_s;
    end else if (top_max > ov_s) begin
      top_s = top_max - ov_s;
    end else begin
      top_s = '0;
    end
    if (bottom_found) begin
      bottom_s = fh_s - $signed({2'b0, bottom_row}) - ov2_s;
    end else if (h2 > 14'sd0) begin
      bottom_s = h2 - h2_half + 14'sd1;
    end else begin
      bottom_s = 14'sd1;
    end
    border_s = (top_s < bottom_s) ? top_s : bottom_s;
    d_s      = {h2[13], h2} - {border_s, 1'b0};
  end

  assign q_push = pending && !q_full;

  always_comb begin
    q_din.top    = top_s[10:0];
    q_din.bottom = bottom_s[11:0];
    q_din.border = border_s[10:0];
    q_din.div_ok = d_s > 15'sd0;
    q_din.h2     = h2[11:0];
    q_din.d      = d_s[11:0];
    q_din.fam    = cfg.aspect_milli;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      bright_count <= '0;
      phase        <= '0;
      top_found    <= 1'b0;
      top_row      <= '0;
      bottom_found <= 1'b0;
      bottom_row   <= '0;
      pending      <= 1'b0;
    end else if (q_push) begin
      pending      <= 1'b0;
      row_count    <= '0;
      top_found    <= 1'b0;
      top_row      <= '0;
      bottom_found <= 1'b0;
      bottom_row   <= '0;
    end else if (accept) begin
      if (line_end || frame_end) begin
        column_count <= '0;
        bright_count <= '0;
        phase        <= '0;
        if (row_count != lbd_pkg::CNT_MAX) row_count <= row_count + 12'd1;
        if (top_hit) begin
          top_found <= 1'b1;
          top_row   <= row_count;
        end
        if (bot_hit) begin
          bottom_found <= 1'b1;
          bottom_row   <= row_count;
        end
        pending <= frame_end;
      end else begin
        bright_count <= bright_inc;
        if (column_count != lbd_pkg::CNT_MAX) column_count <= column_count + 12'd1;
        if (c_s < ov_s) begin
          phase <= '0;
        end else begin
          phase <= (phase_inc == cfg.skip_eff) ? 7'd0 : phase_inc;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/lbd_queue.sv =====
// Short queue of frame summaries between the intake and the ratio unit.
`default_nettype none
module lbd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire lbd_pkg::frame_sum_t din,
  input  wire logic                pop,
  output lbd_pkg::frame_sum_t      dout,
  output logic                     full,
  output logic                     empty
);

  lbd_pkg::frame_sum_t entries [lbd_pkg::QDEPTH];
  logic [lbd_pkg::QPTR_W-1:0] wr_ptr;
  logic [lbd_pkg::QPTR_W-1:0] rd_ptr;
  logic [lbd_pkg::QPTR_W:0]   count;

  assign full  = count == (lbd_pkg::QPTR_W + 1)'(lbd_pkg::QDEPTH);
  assign empty = count == '0;
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= din;
  end

endmodule
`default_nettype wire

// ===== src/lbd_back.sv =====
// Ratio unit: takes a summary, divides when div_ok, holds the result for the receiver.
`default_nettype none
module lbd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire lbd_pkg::frame_sum_t q_dout,
  output logic                     q_pop,
  input  wire logic                ign_busy,
  input  wire lbd_pkg::div_rsp_t   div_rsp,
  output lbd_pkg::div_req_t        div_req,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [10:0]              top_border,
  output logic [11:0]              bottom_border,
  output logic [10:0]              min_border,
  output logic [15:0]              aspect_milli,
  output logic                     ratio_saturated,
  output logic                     back_idle
);

  lbd_pkg::back_state_t state;
  lbd_pkg::back_state_t state_next;
  logic [23:0]          prod;

  assign prod = q_dout.h2 * q_dout.fam;

  always_comb begin
    state_next = state;
    unique case (state)
      lbd_pkg::BK_IDLE: begin
        if (q_pop) state_next = q_dout.div_ok ? lbd_pkg::BK_DIV : lbd_pkg::BK_HOLD;
      end
      lbd_pkg::BK_DIV: begin
        if (div_rsp.done) state_next = lbd_pkg::BK_HOLD;
      end
      lbd_pkg::BK_HOLD: begin
        if (m_tready) state_next = lbd_pkg::BK_IDLE;
      end
      default: state_next = lbd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = (state == lbd_pkg::BK_IDLE) && !q_empty && !div_rsp.busy && !ign_busy;
    div_req.start = q_pop && q_dout.div_ok;
    div_req.num   = lbd_pkg::DIV_NUM_W'(prod);
    div_req.den   = lbd_pkg::DIV_DEN_W'(q_dout.d);
    m_tvalid      = state == lbd_pkg::BK_HOLD;
    back_idle     = state == lbd_pkg::BK_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      top_border    <= q_dout.top;
      bottom_border <= q_dout.bottom;
      min_border    <= q_dout.border;
      if (!q_dout.div_ok) begin
        aspect_milli    <= lbd_pkg::ASPECT_MAX;
        ratio_saturated <= 1'b1;
      end
    end else if (state == lbd_pkg::BK_DIV && div_rsp.done) begin
      if (div_rsp.quo > lbd_pkg::DIV_NUM_W'(lbd_pkg::ASPECT_MAX)) begin
        aspect_milli    <= lbd_pkg::ASPECT_MAX;
        ratio_saturated <= 1'b1;
      end else begin
        aspect_milli    <= div_rsp.quo[15:0];
        ratio_saturated <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
